@@ rtl/core/vpw_pkg.sv @@
package vpw_pkg;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MAC   = 10'b0000000010,
        ST_ROW   = 10'b0000000100,
        ST_DIV   = 10'b0000001000,
        ST_UNIT  = 10'b0000010000,
        ST_SCALE = 10'b0000100000,
        ST_FLIP  = 10'b0001000000,
        ST_OUT   = 10'b0010000000,
        ST_ZERO  = 10'b0100000000,
        ST_WAIT  = 10'b1000000000
    } state_t;

    typedef enum logic [2:0] {
        CFG_VP_X      = 3'd0,
        CFG_VP_Y      = 3'd1,
        CFG_VP_WIDTH  = 3'd2,
        CFG_VP_HEIGHT = 3'd3,
        CFG_SCR_H     = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;

    // returns {saturated, value}
    function automatic logic [32:0] clamp32(input logic signed [71:0] v);
        logic signed [71:0] mx;
        logic signed [71:0] mn;
        begin
            mx = 72'sd2147483647;
            mn = -72'sd2147483648;
            if (v > mx)
            begin
                clamp32 = {1'b1, 32'h7fffffff};
            end
            else if (v < mn)
            begin
                clamp32 = {1'b1, 32'h80000000};
            end
            else
            begin
                clamp32 = {1'b0, v[31:0]};
            end
        end
    endfunction

endpackage

@@ rtl/core/vertex_project_to_window.sv @@
// Projects object points through modelview and projection matrices to window
// coordinates in signed fixed point. op=0 items write one matrix element and give
// no result; op=1 items give one result, computed by the single 32x32
// multiply-accumulate unit that walks 32 matrix terms and the bit-serial divider
// that runs three times. The block takes no new item while one is in progress or
// its result waits. Zero clip w gives ok=0 and zero coordinates.
module vertex_project_to_window #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [12:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic                matrix_select,
    input  logic [3:0]          element_index,
    input  logic signed [31:0]  element_value,
    input  logic signed [31:0]  obj_x,
    input  logic signed [31:0]  obj_y,
    input  logic signed [31:0]  obj_z,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  win_x,
    output logic signed [31:0]  win_y,
    output logic signed [31:0]  win_z,
    output logic                ok,
    output logic                saturated
);
    localparam logic signed [31:0] FxOne  = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] FxHalf = 32'sd1 <<< (FRAC_BITS - 1);

    vpw_pkg::state_t state_reg, state_next;

    logic [11:0] vp_x_reg, vp_y_reg;
    logic [12:0] vp_w_reg, vp_h_reg, scr_h_reg;
    logic [31:0] mem [32];
    logic [31:0] mem_q;
    logic [31:0] id_mask_reg;

    logic signed [31:0] vec_reg [4];
    logic signed [31:0] res_reg [4];
    logic signed [71:0] acc_reg;
    logic [4:0]  term_reg;
    logic        sat_reg;
    logic [1:0]  k_reg;

    logic signed [31:0] out_reg [3];
    logic        ok_reg;
    logic        div_busy_reg;
    vpw_pkg::div_ctl_t div_ctl;
    logic        div_done, div_sat;
    logic signed [31:0] div_q;

    logic signed [63:0] prod;
    logic signed [71:0] psum;
    logic signed [31:0] cl;
    logic        cl_sat;
    logic [4:0]  rd_term;
    logic [4:0]  rd_addr;
    logic [4:0]  cur_addr;
    logic signed [31:0] m_val;
    logic [12:0] vp_size;
    logic [11:0] vp_org;
    logic signed [45:0] scale_prod;
    logic signed [71:0] tmp;
    logic signed [31:0] tmp_cl;
    logic        tmp_sat;

    assign in_ready = (state_reg == vpw_pkg::ST_IDLE);
    assign out_valid = (state_reg == vpw_pkg::ST_OUT);
    assign win_x = out_reg[0];
    assign win_y = out_reg[1];
    assign win_z = out_reg[2];
    assign ok = ok_reg;
    assign saturated = sat_reg;

    // term t: matrix bank t[4], column t[1:0] of vector, row t[3:2]
    // the read runs one term ahead of the multiply
    assign rd_term = (state_reg == vpw_pkg::ST_MAC) ? term_reg + 5'd1 : term_reg;
    assign rd_addr = {rd_term[4], rd_term[1:0], rd_term[3:2]};
    assign cur_addr = {term_reg[4], term_reg[1:0], term_reg[3:2]};
    assign m_val = id_mask_reg[cur_addr] ? signed'(mem_q)
                   : ((term_reg[1:0] == term_reg[3:2]) ? FxOne : 32'sd0);

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && !op)
            mem[{matrix_select, element_index}] <= element_value;
        mem_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            id_mask_reg <= '0;
        else if (in_valid && in_ready && !op)
            id_mask_reg[{matrix_select, element_index}] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_x_reg <= '0;
            vp_y_reg <= '0;
            vp_w_reg <= 13'd640;
            vp_h_reg <= 13'd480;
            scr_h_reg <= 13'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vpw_pkg::CFG_VP_X:      vp_x_reg <= cfg_data[11:0];
                vpw_pkg::CFG_VP_Y:      vp_y_reg <= cfg_data[11:0];
                vpw_pkg::CFG_VP_WIDTH:  vp_w_reg <= cfg_data;
                vpw_pkg::CFG_VP_HEIGHT: vp_h_reg <= cfg_data;
                vpw_pkg::CFG_SCR_H:     scr_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // one multiplier for all matrix terms, floor of product by arithmetic shift
    assign prod = 64'(vec_reg[term_reg[1:0]]) * 64'(m_val);
    assign psum = acc_reg + 72'(prod >>> FRAC_BITS);
    assign {cl_sat, cl} = vpw_pkg::clamp32(acc_reg);

    vpw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   (res_reg[k_reg]),
        .den   (res_reg[3]),
        .done  (div_done),
        .quo   (div_q),
        .sat   (div_sat)
    );

    assign div_ctl = '{start: (state_reg == vpw_pkg::ST_DIV) && !div_busy_reg,
                       busy: div_busy_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vpw_pkg::ST_IDLE:  if (in_valid && op) state_next = vpw_pkg::ST_WAIT;
            vpw_pkg::ST_WAIT:  state_next = vpw_pkg::ST_MAC;
            vpw_pkg::ST_MAC:   if (term_reg[1:0] == 2'd3) state_next = vpw_pkg::ST_ROW;
            vpw_pkg::ST_ROW:
            begin
                if (term_reg == 5'd31)
                    state_next = (cl == 32'sd0) ? vpw_pkg::ST_ZERO
                                                : vpw_pkg::ST_DIV;
                else
                    state_next = vpw_pkg::ST_WAIT;
            end
            vpw_pkg::ST_DIV:   if (div_done) state_next = vpw_pkg::ST_UNIT;
            vpw_pkg::ST_UNIT:  state_next = (k_reg == 2'd2) ? vpw_pkg::ST_SCALE
                                                            : vpw_pkg::ST_DIV;
            vpw_pkg::ST_SCALE: state_next = (k_reg == 2'd1) ? vpw_pkg::ST_FLIP
                                                            : vpw_pkg::ST_SCALE;
            vpw_pkg::ST_FLIP:  state_next = vpw_pkg::ST_OUT;
            vpw_pkg::ST_ZERO:  state_next = vpw_pkg::ST_OUT;
            vpw_pkg::ST_OUT:   if (out_ready) state_next = vpw_pkg::ST_IDLE;
            default:           state_next = vpw_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vpw_pkg::ST_IDLE;
            div_busy_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_ctl.start)
                div_busy_reg <= 1'b1;
            else if (div_done)
                div_busy_reg <= 1'b0;
        end
    end

    assign vp_size = (k_reg == 2'd0) ? vp_w_reg : vp_h_reg;
    assign vp_org = (k_reg == 2'd0) ? vp_x_reg : vp_y_reg;
    assign scale_prod = out_reg[k_reg] * signed'({1'b0, vp_size});

    // unit map, viewport scale and y flip on one add-and-clamp path
    always_comb
    begin
        tmp = '0;
        unique case (state_reg)
            vpw_pkg::ST_UNIT:
                tmp = 72'(div_q >>> 1) + 72'(FxHalf);
            vpw_pkg::ST_SCALE:
                tmp = 72'(scale_prod)
                      + (72'(signed'({1'b0, vp_org})) <<< FRAC_BITS);
            default:
                tmp = (72'(signed'({1'b0, scr_h_reg})) <<< FRAC_BITS) - 72'(out_reg[1]);
        endcase
        {tmp_sat, tmp_cl} = vpw_pkg::clamp32(tmp);
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            vpw_pkg::ST_IDLE:
            begin
                vec_reg[0] <= obj_x;
                vec_reg[1] <= obj_y;
                vec_reg[2] <= obj_z;
                vec_reg[3] <= FxOne;
                acc_reg <= '0;
                term_reg <= '0;
                sat_reg <= 1'b0;
                k_reg <= '0;
                ok_reg <= 1'b1;
            end
            vpw_pkg::ST_MAC:
            begin
                acc_reg <= psum;
                if (term_reg[1:0] != 2'd3)
                    term_reg <= term_reg + 5'd1;
            end
            vpw_pkg::ST_ROW:
            begin
                res_reg[term_reg[3:2]] <= cl;
                if (cl_sat)
                    sat_reg <= 1'b1;
                acc_reg <= '0;
                if (term_reg == 5'd15)
                begin
                    vec_reg[0] <= res_reg[0];
                    vec_reg[1] <= res_reg[1];
                    vec_reg[2] <= res_reg[2];
                    vec_reg[3] <= cl;
                end
                term_reg <= term_reg + 5'd1;
            end
            vpw_pkg::ST_UNIT:
            begin
                out_reg[k_reg] <= tmp_cl;
                if (tmp_sat || div_sat)
                    sat_reg <= 1'b1;
                k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
            end
            vpw_pkg::ST_SCALE:
            begin
                out_reg[k_reg] <= tmp_cl;
                if (tmp_sat)
                    sat_reg <= 1'b1;
                k_reg <= k_reg + 2'd1;
            end
            vpw_pkg::ST_FLIP:
            begin
                out_reg[1] <= tmp_cl;
                if (tmp_sat)
                    sat_reg <= 1'b1;
            end
            vpw_pkg::ST_ZERO:
            begin
                out_reg[0] <= '0;
                out_reg[1] <= '0;
                out_reg[2] <= '0;
                ok_reg <= 1'b0;
            end
            default: ;
        endcase
    end
endmodule

@@ rtl/core/vpw_div.sv @@
// signed restoring divider, one quotient bit per cycle, truncating toward zero
module vpw_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vpw_pkg::div_ctl_t   ctl,
    input  logic signed [31:0]  num,
    input  logic signed [31:0]  den,
    output logic                done,
    output logic signed [31:0]  quo,
    output logic                sat
);
    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]  q_reg, q_next;
    logic [32:0]    r_reg, r_next;
    logic [31:0]    d_reg;
    logic           neg_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           run_reg, run_next;
    logic [33:0]    trial;
    logic [NW:0]    qs;
    logic signed [71:0] qv;

    assign trial = {r_reg, q_reg[NW-1]} - {2'b00, d_reg};

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (run_reg)
        begin
            if (!trial[33])
            begin
                r_next = trial[32:0];
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[31:0], q_reg[NW-1]};
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= ctl.start ? 1'b1 : run_next;
            cnt_reg <= ctl.start ? CW'(NW) : cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            q_reg <= NW'(num[31] ? -{{FRAC_BITS{num[31]}}, num} : {{FRAC_BITS{1'b0}}, num})
                     << FRAC_BITS;
            r_reg <= '0;
            d_reg <= den[31] ? 32'(-den) : den;
            neg_reg <= num[31] ^ den[31];
        end
        else
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign done = ctl.busy && !run_reg && !ctl.start;
    assign qs = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
    assign qv = 72'(signed'(qs));
    assign {sat, quo} = vpw_pkg::clamp32(qv);
endmodule

@@ rtl/core/vpw_checker.sv @@
module vpw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        op,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] win_x,
    input logic        ok
);
    // a result never shows while input is open
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready)) else $error("result and input ready together");

    // a project transfer closes the input
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op |=> !in_ready) else $error("ready after project");

    // a held result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(win_x))
        else $error("result changed while stalled");

    // with ok low (zero w) the result shows zero x
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> win_x == 32'd0) else $error("nonzero x with ok low");
endmodule

bind vertex_project_to_window vpw_checker u_vpw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .win_x     (win_x),
    .ok        (ok)
);
